// ----- hdl/rpnse_pkg.sv -----
// Shared types and constants of the RPN stack evaluator.
// Holds field widths, status and mode codes, operator bytes and the ALU request type.
// No dependencies.
`default_nettype none

package rpnse_pkg;

	// default sizing of the stack and its datapath
	localparam int DEF_STACK_DEPTH = 64;
	localparam int DEF_DATA_WIDTH  = 32;

	// fixed field widths on the channels
	localparam int MODE_W    = 2;
	localparam int NUMBER_W  = 32;
	localparam int OPCHAR_W  = 8;
	localparam int STATUS_W  = 3;
	localparam int ENTRIES_W = 7;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH  = 2'd0,
		MODE_APPLY = 2'd1,
		MODE_POP   = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_DIV0  = 3'd1,
		ST_BADOP = 3'd2,
		ST_UNDER = 3'd3,
		ST_OVER  = 3'd4
	} status_t;

	// operator bytes (ASCII)
	localparam logic [OPCHAR_W-1:0] OP_ADD = 8'h70; // 'p'
	localparam logic [OPCHAR_W-1:0] OP_SUB = 8'h73; // 's'
	localparam logic [OPCHAR_W-1:0] OP_MUL = 8'h2A; // '*'
	localparam logic [OPCHAR_W-1:0] OP_DIV = 8'h2F; // '/'

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_MUL = 2'd2,
		ALU_DIV = 2'd3
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

endpackage

`default_nettype wire

// ----- hdl/rpnse_cmd_if.sv -----
// Command channel of the RPN stack evaluator: valid/ready plus one command item.
// Depends on rpnse_pkg for the field widths.
`default_nettype none

interface rpnse_cmd_if
	import rpnse_pkg::*;
	();

	logic                       valid;
	logic                       ready;
	logic [MODE_W-1:0]          mode;
	logic signed [NUMBER_W-1:0] number;
	logic [OPCHAR_W-1:0]        operator_char;

	modport source (output valid, output mode, output number, output operator_char,
		input ready);
	modport sink (input valid, input mode, input number, input operator_char,
		output ready);

endinterface

`default_nettype wire

// ----- hdl/rpnse_rsp_if.sv -----
// Response channel of the RPN stack evaluator: valid/ready plus one result item.
// Depends on rpnse_pkg for the field widths.
`default_nettype none

interface rpnse_rsp_if
	import rpnse_pkg::*;
	();

	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic signed [NUMBER_W-1:0] top_value;
	logic [ENTRIES_W-1:0]       entries;

	modport source (output valid, output status, output top_value, output entries,
		input ready);
	modport sink (input valid, input status, input top_value, input entries,
		output ready);

endinterface

`default_nettype wire

// ----- hdl/rpn_stack_evaluator_unit.sv -----
// Top level of the RPN stack evaluator: command decode, stack sequencer and result register.
// Depends on rpnse_pkg, rpnse_cmd_if, rpnse_rsp_if, rpnse_ram and rpnse_alu.
//
// Usage:
//   cmd (sink) takes one command per transfer: mode 0 pushes number, mode 1 applies
//   operator_char ('p' add, 's' subtract, '*' multiply, '/' truncating divide) to the
//   top two entries, mode 2 pops the final answer. rsp (source) returns exactly one
//   result per command: status, top_value (top after the step, or the popped answer)
//   and entries (stack depth after the step).
//   The stack lives in a RAM with a registered read; the top entry is kept in a flop.
//   Multiply and divide run one bit per cycle through the single shared adder in rpnse_alu.
//   One command is in flight at a time; cmd.ready is high only while the sequencer idles.
//   With rsp ready, the next command can be taken once the last result is loaded.
//   A finished result sits in the output register, so the next command is taken while
//   rsp is stalled; if that command finishes first it holds until the register frees.
//   Reset clears the stack depth and the output valid; stack contents are not
//   cleared and no entry above the depth is ever shown.
`default_nettype none

module rpn_stack_evaluator_unit
	import rpnse_pkg::*;
#(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
	input wire logic clk,
	input wire logic arst_n,
	rpnse_cmd_if.sink   cmd,
	rpnse_rsp_if.source rsp
);

	localparam int W    = DATA_WIDTH;
	localparam int AW   = $clog2(STACK_DEPTH);
	localparam int CNTW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_CALC = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	// control
	state_t          state_q;
	logic [CNTW-1:0] count_q;
	logic            out_valid_q;

	// payload
	logic [W-1:0]         top_q;
	logic [W-1:0]         ans_q;
	status_t              status_q;
	logic                 popped_q;
	logic                 pop_pend_q;
	alu_op_t              aluop_q;
	status_t              out_status_q;
	logic [NUMBER_W-1:0]  out_top_q;
	logic [ENTRIES_W-1:0] out_entries_q;

	// decode of the command at the transfer
	status_t dec_status;
	state_t  dec_next;
	logic    dec_push, dec_pop, dec_read;
	alu_op_t dec_aluop;

	logic            acc;
	logic [CNTW-1:0] cm2;
	logic [W-1:0]    num_ext;
	logic [W-1:0]    ram_rdata;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [W-1:0]    ram_wdata;
	alu_req_t        alu_req;
	logic            alu_done;
	logic [W-1:0]    alu_result;
	logic            calc_wr;
	logic            fin_load;
	logic [W-1:0]    shown;

	assign cmd.ready = (state_q == S_IDLE);
	assign acc       = cmd.valid && cmd.ready;
	assign cm2       = count_q - CNTW'(2);
	// sign-extend (or truncate) the fixed-width number to the stack width
	assign num_ext   = W'(cmd.number);

	always_comb begin
		dec_status = ST_OK;
		dec_next   = S_FIN;
		dec_push   = 1'b0;
		dec_pop    = 1'b0;
		dec_read   = 1'b0;
		dec_aluop  = ALU_ADD;
		unique case (cmd.mode)
			MODE_PUSH: begin
				if (count_q == CNTW'(STACK_DEPTH)) begin
					dec_status = ST_OVER;
				end else begin
					dec_push = 1'b1;
				end
			end
			MODE_APPLY: begin
				// underflow wins over a bad operator byte
				if (count_q < CNTW'(2)) begin
					dec_status = ST_UNDER;
				end else begin
					case (cmd.operator_char)
						OP_ADD: dec_aluop = ALU_ADD;
						OP_SUB: dec_aluop = ALU_SUB;
						OP_MUL: dec_aluop = ALU_MUL;
						OP_DIV: dec_aluop = ALU_DIV;
						default: dec_status = ST_BADOP;
					endcase
					if (dec_status == ST_OK && dec_aluop == ALU_DIV && top_q == '0) begin
						dec_status = ST_DIV0;
					end
					if (dec_status == ST_OK) begin
						// fetch the entry below the top, then run the ALU
						dec_read = 1'b1;
						dec_next = S_READ;
					end
				end
			end
			MODE_POP: begin
				if (count_q == '0) begin
					dec_status = ST_UNDER;
				end else begin
					dec_pop = 1'b1;
					// refill the cached top unless the stack empties
					if (count_q >= CNTW'(2)) begin
						dec_read = 1'b1;
						dec_next = S_READ;
					end
				end
			end
			default: dec_status = ST_BADOP;
		endcase
	end

	// stack RAM: push writes at the depth, an operator writes its result over the lower
	// operand; both reads fetch the entry just below the top
	assign calc_wr   = (state_q == S_CALC) && alu_done;
	assign ram_we    = (acc && dec_push) || calc_wr;
	assign ram_waddr = calc_wr ? cm2[AW-1:0] : count_q[AW-1:0];
	assign ram_wdata = calc_wr ? alu_result : num_ext;

	rpnse_ram #(
		.WIDTH (W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (acc && dec_read),
		.raddr (cm2[AW-1:0]),
		.rdata (ram_rdata)
	);

	// a is the lower entry, b the cached top
	assign alu_req.start = (state_q == S_READ) && !pop_pend_q;
	assign alu_req.op    = aluop_q;

	rpnse_alu #(
		.DATA_WIDTH (W)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (ram_rdata),
		.b      (top_q),
		.done   (alu_done),
		.result (alu_result)
	);

	assign fin_load = (state_q == S_FIN) && (!out_valid_q || rsp.ready);

	// show the popped answer, else the top, else zero on an empty stack
	assign shown = popped_q ? ans_q : ((count_q == '0) ? '0 : top_q);

	// sequencer and depth counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= dec_next;
						if (dec_push) begin
							count_q <= count_q + CNTW'(1);
						end else if (dec_pop) begin
							count_q <= count_q - CNTW'(1);
						end
					end
				end
				S_READ: state_q <= pop_pend_q ? S_FIN : S_CALC;
				S_CALC: begin
					if (alu_done) begin
						count_q <= count_q - CNTW'(1);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			status_q   <= dec_status;
			popped_q   <= dec_pop;
			pop_pend_q <= dec_pop;
			aluop_q    <= dec_aluop;
			ans_q      <= top_q;
			if (dec_push) begin
				top_q <= num_ext;
			end
		end
		// pop: the entry below becomes the cached top
		if (state_q == S_READ && pop_pend_q) begin
			top_q <= ram_rdata;
		end
		if (calc_wr) begin
			top_q <= alu_result;
		end
		if (fin_load) begin
			out_status_q  <= status_q;
			out_top_q     <= NUMBER_W'(shown);
			out_entries_q <= ENTRIES_W'(count_q);
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.top_value = out_top_q;
	assign rsp.entries   = out_entries_q;

	// depth never passes the stack size
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	// a push into a stack with room grows it by one
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cmd.mode == MODE_PUSH && count_q != CNTW'(STACK_DEPTH))
		|=> count_q == $past(count_q) + CNTW'(1))
		else $error("push did not grow the stack");

	// the ALU only finishes while the sequencer waits for it
	a_alu_done_calc: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> state_q == S_CALC)
		else $error("ALU result with no operator pending");

	// every transfer leaves idle, so no command is dropped
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q != S_IDLE)
		else $error("command taken but sequencer stayed idle");

	// a result is loaded only from the finish state
	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FIN)
		else $error("result register loaded outside finish");

endmodule

`default_nettype wire

// ----- hdl/rpnse_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rpnse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/rpnse_alu.sv -----
// Iterative ALU of the RPN stack evaluator: one shared adder serves add, subtract,
// shift-add multiply, sign fixes and restoring divide. Depends on rpnse_pkg.
`default_nettype none

module rpnse_alu
	import rpnse_pkg::*;
#(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire alu_req_t              req,
	input  wire logic [DATA_WIDTH-1:0] a,
	input  wire logic [DATA_WIDTH-1:0] b,
	output      logic                  done,
	output      logic [DATA_WIDTH-1:0] result
);

	localparam int W  = DATA_WIDTH;
	localparam int CW = $clog2(W);

	typedef enum logic [5:0] {
		P_IDLE = 6'b000001,
		P_ONE  = 6'b000010,
		P_NEGA = 6'b000100,
		P_NEGB = 6'b001000,
		P_LOOP = 6'b010000,
		P_FIX  = 6'b100000
	} phase_t;

	phase_t        phase_q;
	alu_op_t       op_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic          neg_q;
	logic [W-1:0]  x_q;   // accumulator / partial remainder
	logic [W-1:0]  y_q;   // multiplicand / divisor
	logic [W-1:0]  z_q;   // multiplier bits / dividend shifting into quotient
	logic [W-1:0]  res_q;

	logic [W-1:0] opx, opy, rem_sh, sum;
	logic         sub, cout;

	assign rem_sh = {x_q[W-2:0], z_q[W-1]};

	// shared adder operand select
	always_comb begin
		opx = '0;
		opy = '0;
		sub = 1'b0;
		unique case (phase_q)
			P_ONE: begin
				opx = x_q;
				opy = y_q;
				sub = (op_q == ALU_SUB);
			end
			P_LOOP: begin
				if (op_q == ALU_DIV) begin
					opx = rem_sh;
					opy = y_q;
					sub = 1'b1;
				end else begin
					opx = x_q;
					opy = z_q[0] ? y_q : '0;
				end
			end
			P_NEGA, P_FIX: begin
				opy = z_q;
				sub = 1'b1;
			end
			P_NEGB: begin
				opy = y_q;
				sub = 1'b1;
			end
			default: begin
				opx = '0;
			end
		endcase
	end

	assign {cout, sum} = {1'b0, opx} + {1'b0, (sub ? ~opy : opy)} + (W+1)'(sub);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					cnt_q <= CW'(W - 1);
					if (req.start) begin
						unique case (req.op)
							ALU_ADD, ALU_SUB: phase_q <= P_ONE;
							ALU_MUL:          phase_q <= P_LOOP;
							default:          phase_q <= P_NEGA;
						endcase
					end
				end
				P_ONE: begin
					phase_q <= P_IDLE;
					done_q  <= 1'b1;
				end
				P_NEGA: phase_q <= P_NEGB;
				P_NEGB: phase_q <= P_LOOP;
				P_LOOP: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						if (op_q == ALU_DIV) begin
							phase_q <= P_FIX;
						end else begin
							phase_q <= P_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				P_FIX: begin
					phase_q <= P_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (phase_q)
			P_IDLE: begin
				if (req.start) begin
					op_q  <= req.op;
					neg_q <= a[W-1] ^ b[W-1];
					unique case (req.op)
						ALU_ADD, ALU_SUB: begin
							x_q <= a;
							y_q <= b;
						end
						ALU_MUL: begin
							x_q <= '0;
							y_q <= a;
							z_q <= b;
						end
						default: begin
							x_q <= '0;
							y_q <= b;
							z_q <= a;
						end
					endcase
				end
			end
			P_ONE: res_q <= sum;
			P_NEGA: begin
				if (z_q[W-1]) begin
					z_q <= sum;
				end
			end
			P_NEGB: begin
				if (y_q[W-1]) begin
					y_q <= sum;
				end
			end
			P_LOOP: begin
				if (op_q == ALU_DIV) begin
					x_q <= cout ? sum : rem_sh;
					z_q <= {z_q[W-2:0], cout};
				end else begin
					x_q   <= sum;
					y_q   <= {y_q[W-2:0], 1'b0};
					z_q   <= {1'b0, z_q[W-1:1]};
					res_q <= sum;
				end
			end
			P_FIX: res_q <= neg_q ? sum : z_q;
			default: res_q <= res_q;
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire
